// File: sv/u8d_pkg.sv
package u8d_pkg;

  // Queue between classifier and accumulator
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CpW = 31;

  // Sequence length codes carried with each classified word
  localparam logic [2:0] LEN_STRAY = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;
  localparam logic [2:0] LEN_FIVE  = 3'd5;
  localparam logic [2:0] LEN_SIX   = 3'd6;

  // Range limits per sequence length
  localparam logic [CpW-1:0] MAX_ONE   = 31'h0000007F;
  localparam logic [CpW-1:0] MIN_TWO   = 31'h00000080;
  localparam logic [CpW-1:0] MAX_TWO   = 31'h000007FF;
  localparam logic [CpW-1:0] MIN_THREE = 31'h00000800;
  localparam logic [CpW-1:0] MAX_THREE = 31'h0000FFFF;
  localparam logic [CpW-1:0] MIN_FOUR  = 31'h00010000;
  localparam logic [CpW-1:0] MAX_FOUR  = 31'h001FFFFF;
  localparam logic [CpW-1:0] MIN_FIVE  = 31'h00200000;
  localparam logic [CpW-1:0] MAX_FIVE  = 31'h03FFFFFF;
  localparam logic [CpW-1:0] MIN_SIX   = 31'h04000000;
  localparam logic [CpW-1:0] MAX_SIX   = 31'h7FFFFFFF;

  // One classified word: raw byte plus its meaning as a lead byte
  typedef struct packed {
    logic [7:0] raw;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
  } cls_word_t;

  // Queue head as seen by the accumulator
  typedef struct packed {
    logic      not_empty;
    cls_word_t head;
  } q_status_t;

  function automatic logic in_range(input logic [2:0] len, input logic [CpW-1:0] v);
    logic ok;
    begin
      case (len)
        LEN_ONE:   ok = (v <= MAX_ONE);
        LEN_TWO:   ok = (v >= MIN_TWO) && (v <= MAX_TWO);
        LEN_THREE: ok = (v >= MIN_THREE) && (v <= MAX_THREE);
        LEN_FOUR:  ok = (v >= MIN_FOUR) && (v <= MAX_FOUR);
        LEN_FIVE:  ok = (v >= MIN_FIVE) && (v <= MAX_FIVE);
        LEN_SIX:   ok = (v >= MIN_SIX) && (v <= MAX_SIX);
        default:   ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

endpackage

// File: sv/u8d_front.sv
module u8d_front (
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  input  logic               q_full,
  output logic               in_stall,
  output logic               q_push,
  output u8d_pkg::cls_word_t q_word
);

  // Hold off the source while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the word as a lead byte
  always_comb begin
    q_word.raw       = in_data_byte;
    q_word.lead_len  = u8d_pkg::LEN_STRAY;
    q_word.lead_bits = 5'd0;
    unique case (in_data_byte) inside
      [8'h00:8'h7F]: q_word.lead_len = u8d_pkg::LEN_ONE;
      [8'hC0:8'hDF]: begin
        q_word.lead_len  = u8d_pkg::LEN_TWO;
        q_word.lead_bits = in_data_byte[4:0];
      end
      [8'hE0:8'hEF]: begin
        q_word.lead_len  = u8d_pkg::LEN_THREE;
        q_word.lead_bits = {1'b0, in_data_byte[3:0]};
      end
      [8'hF0:8'hF7]: begin
        q_word.lead_len  = u8d_pkg::LEN_FOUR;
        q_word.lead_bits = {2'b0, in_data_byte[2:0]};
      end
      [8'hF8:8'hFB]: begin
        q_word.lead_len  = u8d_pkg::LEN_FIVE;
        q_word.lead_bits = {3'b0, in_data_byte[1:0]};
      end
      [8'hFC:8'hFD]: begin
        q_word.lead_len  = u8d_pkg::LEN_SIX;
        q_word.lead_bits = {4'b0, in_data_byte[0]};
      end
      default: q_word.lead_len = u8d_pkg::LEN_STRAY;
    endcase
  end

endmodule

// File: sv/u8d_queue.sv
module u8d_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8d_pkg::cls_word_t push_word,
  input  logic               pop,
  output logic               full,
  output u8d_pkg::q_status_t status
);

  u8d_pkg::cls_word_t                 mem_r [u8d_pkg::QDepth];
  logic [u8d_pkg::QPtrW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [u8d_pkg::QPtrW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [u8d_pkg::QCntW-1:0]          count_r, count_nxt;

  assign full             = (count_r == u8d_pkg::QCntW'(u8d_pkg::QDepth));
  assign status.not_empty = (count_r != '0);
  assign status.head      = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= u8d_pkg::QCntW'(u8d_pkg::QDepth))
    else $error("queue occupancy beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> status.not_empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: sv/u8d_back.sv
module u8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  u8d_pkg::q_status_t         status,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [u8d_pkg::CpW-1:0]    out_code_point,
  output logic                       out_is_valid
);

  logic [2:0]                  bytes_left_r, bytes_left_nxt;
  logic [2:0]                  seq_length_r, seq_length_nxt;
  logic [u8d_pkg::CpW-1:0]     accum_r, accum_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [u8d_pkg::CpW-1:0]     out_cp_r, out_cp_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic                        emit;
  logic [5:0]                  add;
  u8d_pkg::cls_word_t          w;

  assign w   = status.head;
  assign pop = status.not_empty && (!out_valid_r || !out_stall);
  assign add = w.raw[7] ? w.raw[5:0] : 6'd0;

  // Step the sequence state with the popped word
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_length_nxt = seq_length_r;
    accum_nxt      = accum_r;
    emit           = 1'b0;
    out_cp_nxt     = out_cp_r;
    out_ok_nxt     = out_ok_r;
    if (pop) begin
      if (bytes_left_r != 3'd0) begin
        accum_nxt      = {accum_r[u8d_pkg::CpW-7:0], add};
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          emit       = 1'b1;
          out_cp_nxt = accum_nxt;
          out_ok_nxt = u8d_pkg::in_range(seq_length_r, accum_nxt);
        end
      end else begin
        case (w.lead_len)
          u8d_pkg::LEN_ONE: begin
            seq_length_nxt = u8d_pkg::LEN_ONE;
            accum_nxt      = u8d_pkg::CpW'(w.raw);
            emit           = 1'b1;
            out_cp_nxt     = u8d_pkg::CpW'(w.raw);
            out_ok_nxt     = 1'b1;
          end
          u8d_pkg::LEN_STRAY: begin
            emit       = 1'b1;
            out_cp_nxt = '0;
            out_ok_nxt = 1'b0;
          end
          default: begin
            seq_length_nxt = w.lead_len;
            accum_nxt      = u8d_pkg::CpW'(w.lead_bits);
            bytes_left_nxt = w.lead_len - 3'd1;
          end
        endcase
      end
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_length_r <= '0;
      accum_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      seq_length_r <= seq_length_nxt;
      accum_r      <= accum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    out_cp_r <= out_cp_nxt;
    out_ok_r <= out_ok_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_is_valid   = out_ok_r;

`ifndef SYNTH
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= 3'd5)
    else $error("too many continuation bytes pending");
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != 3'd0) |-> (seq_length_r >= 3'd2 && seq_length_r <= 3'd6 &&
                                bytes_left_r < seq_length_r))
    else $error("open sequence with bad length");
  a_emit_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(pop))
    else $error("result appeared without a popped word");
`endif

endmodule

// File: sv/utf8_sequence_decoder_top.sv
// UTF-8 decoder, original six-byte form, code points up to 31 bits.
// Input channel: one byte per word on in_data_byte, taken when in_valid is
// high and in_stall is low. Output channel: one word per completed sequence
// or stray byte, out_code_point and out_is_valid, taken when out_valid is
// high and out_stall is low. Bytes inside a sequence produce no output.
// Throughput: one byte per cycle while out_stall stays low. A classifier
// writes each byte into a four-entry queue; the accumulator pops one word
// per cycle into the output register unless a stalled output word holds.
// A completing byte is queued first, then registered into the output word.
// When the receiver stalls, the output word holds, the accumulator stops
// and the queue fills; in_stall rises once four words are waiting.
// Reset (rst_n low, synchronous) empties the queue, drops any output word
// and closes any open sequence. An unfinished sequence is never flushed.
module utf8_sequence_decoder_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [7:0]              in_data_byte,
  output logic                    in_stall,
  output logic                    out_valid,
  output logic [u8d_pkg::CpW-1:0] out_code_point,
  output logic                    out_is_valid,
  input  logic                    out_stall
);

  u8d_pkg::cls_word_t q_word;
  u8d_pkg::q_status_t q_status;
  logic               q_push;
  logic               q_pop;
  logic               q_full;

  u8d_front u_front (
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .q_push       (q_push),
    .q_word       (q_word)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .pop       (q_pop),
    .full      (q_full),
    .status    (q_status)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .status         (q_status),
    .pop            (q_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_is_valid   (out_is_valid)
  );

endmodule
